// ===== hdl/rtu_pkg.sv =====
// Shared types, constants and helpers for the PCX run-length tile unpacker.
package rtu_pkg;

	// Geometry registers are 11 bits wide; tiles are 8x8 pixels.
	localparam int GEOM_W     = 11;
	localparam int TILE_SHIFT = 3;
	localparam int TILE_IDX_W = 2 * (GEOM_W - TILE_SHIFT);
	localparam int ADDR_W     = 20;
	localparam int CFG_IDX_W  = 1;
	localparam int CLAMP_W    = 13;

	localparam logic [GEOM_W-1:0] GEOM_RESET = 11'd256;
	localparam logic [GEOM_W-1:0] GEOM_MIN   = 11'd8;
	localparam logic [7:0]        RUN_MARK   = 8'hC0;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

	// One input item of the compressed stream.
	typedef struct packed {
		logic [7:0] stream_byte;
		logic       image_start;
	} stream_item_t;

	// One result item: a pixel and its tile-ordered address.
	typedef struct packed {
		logic [ADDR_W-1:0] pixel_address;
		logic [7:0]        pixel_index;
		logic              run_last;
		logic              image_done;
	} pixel_item_t;

	// Command from the byte classifier to the pixel sequencer.
	// A count of zero only advances the row bookkeeping.
	typedef struct packed {
		logic       start;
		logic [5:0] count;
		logic [7:0] pix;
	} rtu_cmd_t;

	// Image geometry as written through the configuration port.
	typedef struct packed {
		logic [GEOM_W-1:0] width;
		logic [GEOM_W-1:0] height;
	} rtu_geom_t;

	// Round down to a multiple of eight, then clamp to [8, maxv].
	function automatic logic [GEOM_W-1:0] eff_dim(input logic [GEOM_W-1:0] v,
			input logic [CLAMP_W-1:0] maxv);
		logic [GEOM_W-1:0] r;
		r = {v[GEOM_W-1:TILE_SHIFT], {TILE_SHIFT{1'b0}}};
		if (r < GEOM_MIN) begin
			r = GEOM_MIN;
		end
		if ({{(CLAMP_W-GEOM_W){1'b0}}, r} > maxv) begin
			r = maxv[GEOM_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== hdl/rtu_fifo.sv =====
// Small register-based first-in first-out queue.
module rtu_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_wr, do_rd;

	assign full    = (cnt_q == FULL_CNT);
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Storage needs no reset.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ===== hdl/rtu_front.sv =====
// Byte classifier: pairs run markers with their index bytes and issues commands.
module rtu_front
	import rtu_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  stream_item_t stream_item,
	output logic         full,
	input  logic         cmd_full,
	output logic         cmd_push,
	output rtu_cmd_t     cmd
);
	logic       pending_q;
	logic [5:0] run_cnt_q;
	logic       pend;
	logic       is_mark;
	logic       accept;

	assign full     = cmd_full;
	assign accept   = push && !cmd_full;
	assign cmd_push = accept;

	// A new image drops any half-read run marker.
	assign pend    = pending_q && !stream_item.image_start;
	assign is_mark = (stream_item.stream_byte >= RUN_MARK);

	// Every item becomes one command; a marker only advances bookkeeping.
	always_comb begin
		cmd.start = stream_item.image_start;
		cmd.pix   = stream_item.stream_byte;
		if (pend) begin
			cmd.count = run_cnt_q;
		end else if (is_mark) begin
			cmd.count = 6'd0;
		end else begin
			cmd.count = 6'd1;
		end
	end

	// Marker pairing state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
			run_cnt_q <= '0;
		end else if (accept) begin
			if (pend) begin
				pending_q <= 1'b0;
			end else if (is_mark) begin
				pending_q <= 1'b1;
				run_cnt_q <= 6'(stream_item.stream_byte - RUN_MARK);
			end else begin
				pending_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hdl/rtu_back.sv =====
// Pixel sequencer: tracks the raster position and emits one addressed pixel a cycle in S_EMIT unless out_full.
module rtu_back
	import rtu_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  rtu_geom_t   geom,
	input  logic        cmd_empty,
	input  rtu_cmd_t    cmd,
	output logic        cmd_pop,
	input  logic        out_full,
	output logic        out_push,
	output pixel_item_t out_item
);
	typedef enum logic [1:0] {S_TAKE, S_BASE, S_EMIT} state_t;

	state_t                state_q;
	logic [GEOM_W-1:0]     column_q, row_q;
	logic                  finished_q;
	logic [5:0]            cnt_q;
	logic [7:0]            pix_q;
	logic [TILE_IDX_W-1:0] base_q;

	logic [GEOM_W-1:0]     w, h;
	logic [GEOM_W-1:0]     col0, row0, col1, row1;
	logic                  fin0, fin1;
	logic                  row_end, img_end;
	logic [GEOM_W-1:0]     row_next;
	logic [TILE_IDX_W-1:0] tile;

	assign w = eff_dim(geom.width, CLAMP_W'(MAX_WIDTH));
	assign h = eff_dim(geom.height, CLAMP_W'(MAX_HEIGHT));

	// Restart, late row wrap and end-of-image check for the next command.
	always_comb begin
		col0 = cmd.start ? '0 : column_q;
		row0 = cmd.start ? '0 : row_q;
		fin0 = cmd.start ? 1'b0 : finished_q;
		if (!fin0 && col0 >= w) begin
			col1 = '0;
			row1 = row0 + 1'b1;
		end else begin
			col1 = col0;
			row1 = row0;
		end
		fin1 = fin0 || (row1 >= h);
	end

	// Position of the pixel being emitted.
	assign row_next = row_q + 1'b1;
	assign row_end  = ({1'b0, column_q} + 1'b1) == {1'b0, w};
	assign img_end  = row_end && (row_next == h);
	assign tile     = base_q + TILE_IDX_W'(column_q[GEOM_W-1:TILE_SHIFT]);

	always_comb begin
		out_item.pixel_address = ADDR_W'({tile, row_q[TILE_SHIFT-1:0],
			column_q[TILE_SHIFT-1:0]});
		out_item.pixel_index   = pix_q;
		out_item.run_last      = (cnt_q == 6'd1) || row_end;
		out_item.image_done    = img_end;
	end

	assign cmd_pop  = (state_q == S_TAKE) && !cmd_empty;
	assign out_push = (state_q == S_EMIT) && !out_full;

	// Sequencer state and raster position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_TAKE;
			column_q   <= '0;
			row_q      <= '0;
			finished_q <= 1'b0;
			cnt_q      <= '0;
			pix_q      <= '0;
			base_q     <= '0;
		end else begin
			case (state_q)
				S_TAKE: begin
					if (!cmd_empty) begin
						column_q   <= col1;
						row_q      <= row1;
						finished_q <= fin1;
						cnt_q      <= cmd.count;
						pix_q      <= cmd.pix;
						if (!fin1 && cmd.count != 6'd0) begin
							state_q <= S_BASE;
						end
					end
				end
				S_BASE: begin
					// First tile number of the current tile row.
					base_q  <= TILE_IDX_W'(row_q[GEOM_W-1:TILE_SHIFT])
						* TILE_IDX_W'(w[GEOM_W-1:TILE_SHIFT]);
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (!out_full) begin
						cnt_q <= cnt_q - 1'b1;
						if (row_end) begin
							column_q   <= '0;
							row_q      <= row_next;
							finished_q <= (row_next >= h);
							state_q    <= S_TAKE;
						end else begin
							column_q <= column_q + 1'b1;
							if (cnt_q == 6'd1) begin
								state_q <= S_TAKE;
							end
						end
					end
				end
				default: begin
					state_q <= S_TAKE;
				end
			endcase
		end
	end

endmodule

// ===== hdl/pcx_rle_tile_unpacker.sv =====
// Top level of the PCX run-length decoder with 8x8 tile-ordered pixel addresses.
// A literal byte's pixel passes the command queue, the sequencer's take, base and emit states
// and the result queue before it is on the result ports. The sequencer handles a run marker
// in its take state alone, and a literal byte or a run through take, base and emit; it finishes
// one command before it takes the next and sets the rate, and a four-entry command queue absorbs
// bursts. Reset clears the queues and raster position and sets both geometry registers to 256.
module pcx_rle_tile_unpacker
	import rtu_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  stream_item_t         stream_item,
	output logic                 empty,
	input  logic                 pop,
	output pixel_item_t          result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [GEOM_W-1:0]    cfg_data
);
	localparam int CMD_DEPTH = 4;
	localparam int OUT_DEPTH = 2;

	rtu_geom_t   geom_q;
	logic        cmd_push, cmd_pop, cmd_full, cmd_empty;
	rtu_cmd_t    cmd_in, cmd_out;
	logic        out_push, out_full;
	pixel_item_t out_item;

	// Geometry registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geom_q.width  <= GEOM_RESET;
			geom_q.height <= GEOM_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH:  geom_q.width  <= cfg_data;
				CFG_IMAGE_HEIGHT: geom_q.height <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Front: byte classification.
	rtu_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.stream_item (stream_item),
		.full        (full),
		.cmd_full    (cmd_full),
		.cmd_push    (cmd_push),
		.cmd         (cmd_in)
	);

	// Command queue between front and back.
	rtu_fifo #(
		.WIDTH ($bits(rtu_cmd_t)),
		.DEPTH (CMD_DEPTH)
	) u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (cmd_in),
		.rd_en   (cmd_pop),
		.rd_data (cmd_out),
		.full    (cmd_full),
		.empty   (cmd_empty)
	);

	// Back: pixel sequencing and addressing.
	rtu_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.geom      (geom_q),
		.cmd_empty (cmd_empty),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.out_full  (out_full),
		.out_push  (out_push),
		.out_item  (out_item)
	);

	// Result queue toward the consumer.
	rtu_fifo #(
		.WIDTH ($bits(pixel_item_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (out_push),
		.wr_data (out_item),
		.rd_en   (pop),
		.rd_data (result),
		.full    (out_full),
		.empty   (empty)
	);

endmodule

// ===== hdl/rtu_checker.sv =====
// Port-level assertions for the tile unpacker, bound to the top level.
module rtu_checker
	import rtu_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        full,
	input logic        empty,
	input logic        pop,
	input pixel_item_t result
);
	logic       mid_run_q;
	logic [7:0] prev_index_q;

	// Remember whether the last taken item left a run unfinished.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_run_q    <= 1'b0;
			prev_index_q <= '0;
		end else if (pop && !empty) begin
			mid_run_q    <= !result.run_last;
			prev_index_q <= result.pixel_index;
		end
	end

	// The result queue is empty and the input side is not full on the edge after reset is seen.
	a_reset_drained: assert property (@(posedge clk)
		!arst_n |=> (empty && !full))
		else $error("queues not drained after reset");

	// A waiting result holds until it is taken.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("waiting result changed or vanished");

	// Pixels of one run all carry the same palette index.
	a_run_index: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && mid_run_q) |-> (result.pixel_index == prev_index_q))
		else $error("palette index changed inside a run");

	// The final pixel closes its row and is the last corner of its tile.
	a_done_corner: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.image_done) |->
			(result.run_last && result.pixel_address[5:0] == 6'h3F))
		else $error("image end flagged on a pixel that is not a tile corner");

endmodule

bind pcx_rle_tile_unpacker rtu_checker u_rtu_checker (.*);
